// ===== rtl/ufc_pkg.sv =====
// Shared types, constants and the CRC byte step for the UF2 framer.
// Used by ufc_ctrl, ufc_datapath and the top level; no dependencies.
package ufc_pkg;

  localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_A       = 32'h0A32_4655;
  localparam logic [31:0] MAGIC_B       = 32'h9E5D_5157;
  localparam logic [31:0] MAGIC_Z       = 32'h0AB1_6F30;
  localparam logic [31:0] FLAG_FAMILY   = 32'h0000_2000;
  localparam logic [31:0] BLOCK_PAYLOAD = 32'd256;

  localparam logic [0:0]  RST_OUTPUT_MODE  = 1'b0;
  localparam logic [16:0] RST_TOTAL_BLOCKS = 17'd1;
  localparam logic [31:0] RST_BASE_ADDRESS = 32'h1000_0000;
  localparam logic [31:0] RST_FAMILY_WORD  = 32'hE48B_FF56;

  localparam logic [1:0] CFG_OUTPUT_MODE  = 2'd0;
  localparam logic [1:0] CFG_TOTAL_BLOCKS = 2'd1;
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd2;
  localparam logic [1:0] CFG_FAMILY_WORD  = 2'd3;

  localparam logic [4:0] FILL_LAST = 5'd26;
  localparam logic [3:0] FULL_WORD = 4'd8;

  typedef enum logic [2:0] {
    SEL_HDR0,
    SEL_HDR1,
    SEL_HDR2,
    SEL_HDR3,
    SEL_DATA,
    SEL_RAW,
    SEL_ZERO,
    SEL_MAGIC
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      crc;
    logic      half;
    logic      pad;
    logic      finish;
    logic      emit;
    emit_sel_e sel;
  } ufc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic raw_mode;
    logic final_item;
    logic wib_zero;
    logic wib_last;
  } ufc_sts_t;

  function automatic logic [31:0] crc8_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/ufc_ctrl.sv =====
// Sequencing state machine for the UF2 framer: accept, CRC halves, emission.
// Depends on ufc_pkg; drives ufc_datapath through ufc_cmd_t.
module ufc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ufc_pkg::ufc_sts_t sts_i,
  output ufc_pkg::ufc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HALF0,
    ST_HALF1,
    ST_RAW,
    ST_HDR,
    ST_DATA,
    ST_FILL,
    ST_MAGIC
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] seq_q, seq_d;

  always_comb begin
    state_d    = state_q;
    seq_d      = seq_q;
    in_ready_o = (state_q == ST_IDLE);
    cmd_o      = '0;
    cmd_o.sel  = ufc_pkg::SEL_DATA;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_HALF0;
        end
      end
      ST_HALF0: begin
        cmd_o.crc  = 1'b1;
        cmd_o.half = 1'b0;
        state_d    = ST_HALF1;
      end
      ST_HALF1: begin
        cmd_o.crc  = 1'b1;
        cmd_o.half = 1'b1;
        if (sts_i.raw_mode) begin
          state_d = ST_RAW;
        end else if (sts_i.wib_zero) begin
          state_d = ST_HDR;
          seq_d   = '0;
        end else begin
          state_d = ST_DATA;
        end
      end
      ST_RAW: begin
        cmd_o.sel = ufc_pkg::SEL_RAW;
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_HDR: begin
        case (seq_q[1:0])
          2'd0:    cmd_o.sel = ufc_pkg::SEL_HDR0;
          2'd1:    cmd_o.sel = ufc_pkg::SEL_HDR1;
          2'd2:    cmd_o.sel = ufc_pkg::SEL_HDR2;
          default: cmd_o.sel = ufc_pkg::SEL_HDR3;
        endcase
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (seq_q[1:0] == 2'd3) begin
            state_d = ST_DATA;
            seq_d   = '0;
          end else begin
            seq_d = seq_q + 5'd1;
          end
        end
      end
      ST_DATA: begin
        cmd_o.sel = ufc_pkg::SEL_DATA;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.final_item && !sts_i.wib_last) begin
            cmd_o.pad = 1'b1;
            state_d   = ST_HALF0;
          end else if (sts_i.wib_last) begin
            state_d = ST_FILL;
            seq_d   = '0;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_FILL: begin
        cmd_o.sel = ufc_pkg::SEL_ZERO;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (seq_q == ufc_pkg::FILL_LAST) begin
            state_d = ST_MAGIC;
            seq_d   = '0;
          end else begin
            seq_d = seq_q + 5'd1;
          end
        end
      end
      ST_MAGIC: begin
        cmd_o.sel = ufc_pkg::SEL_MAGIC;
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seq_q   <= '0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
    end
  end

endmodule

// ===== rtl/ufc_datapath.sv =====
// Datapath of the UF2 framer: config registers, CRC and patching, block
// counters and the output register. Depends on ufc_pkg; driven by ufc_ctrl.
module ufc_datapath #(
  parameter int MAX_BLOCKS        = 65536,
  parameter int BOOT_REGION_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [63:0]       in_word_i,
  input  logic [3:0]        in_count_i,
  input  logic              in_last_i,
  input  ufc_pkg::ufc_cmd_t cmd_i,
  output ufc_pkg::ufc_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [63:0]       out_word_o,
  output logic [3:0]        out_bytes_o,
  output logic              out_eos_o,
  output logic              out_err_o
);

  localparam int BW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = ((BW > 17) ? BW : 17) + 1;
  localparam int OW = 10;
  localparam logic [BW-1:0] MaxBlk = BW'(MAX_BLOCKS);
  localparam logic [OW-1:0] Boot   = OW'(BOOT_REGION_BYTES);

  logic        mode_q;
  logic [16:0] total_q;
  logic [31:0] base_q;
  logic [31:0] family_q;

  logic [31:0]   crc_q;
  logic [BW-1:0] block_q;
  logic [4:0]    wib_q;
  logic          done_q;

  logic [63:0] in_word_q;
  logic [3:0]  cnt_q;
  logic        final_q;
  logic        err_q;
  logic [63:0] pw_q;

  logic        out_valid_q;
  logic [63:0] out_word_q;
  logic [3:0]  out_bytes_q;
  logic        out_eos_q;
  logic        out_err_q;

  logic [3:0]    cnt_eff;
  logic          err_now;
  logic          active;
  logic [31:0]   crc_t;
  logic          done_t;
  logic [31:0]   half_out;
  logic [2:0]    lane;
  logic [OW-1:0] off;
  logic [7:0]    bval;
  logic [7:0]    pbyte;
  logic [1:0]    sh;
  logic [63:0]   raw_word;
  logic [63:0]   emit_word;
  logic [31:0]   addr;

  assign cnt_eff = (!in_last_i || in_count_i == 4'd0 || in_count_i > ufc_pkg::FULL_WORD)
                   ? ufc_pkg::FULL_WORD : in_count_i;
  assign err_now = (block_q >= MaxBlk) || ((CW'(block_q) + CW'(1)) != CW'(total_q));
  assign active  = !done_q && (block_q == '0);
  assign addr    = base_q + 32'({block_q, 8'h00});

  always_comb begin
    crc_t    = crc_q;
    done_t   = 1'b0;
    half_out = '0;
    lane     = '0;
    off      = '0;
    bval     = '0;
    pbyte    = '0;
    sh       = '0;
    for (int j = 0; j < 4; j++) begin
      lane = {cmd_i.half, 2'(j)};
      off  = {2'b00, wib_q, lane};
      bval = in_word_q[{lane, 3'b000} +: 8];
      if ({1'b0, lane} >= cnt_q) begin
        bval = 8'hFF;
      end
      pbyte = bval;
      if (active && off < Boot) begin
        if (off + OW'(4) < Boot) begin
          crc_t = ufc_pkg::crc8_step(crc_t, bval);
        end else begin
          sh    = 2'(off + OW'(4) - Boot);
          pbyte = crc_t[{sh, 3'b000} +: 8];
          if (off + OW'(1) == Boot) begin
            done_t = 1'b1;
          end
        end
      end
      half_out[j*8 +: 8] = pbyte;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      raw_word[i*8 +: 8] = (4'(i) < cnt_q) ? pw_q[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      ufc_pkg::SEL_HDR0:  emit_word = {ufc_pkg::MAGIC_B, ufc_pkg::MAGIC_A};
      ufc_pkg::SEL_HDR1:  emit_word = {addr, ufc_pkg::FLAG_FAMILY};
      ufc_pkg::SEL_HDR2:  emit_word = {32'(block_q), ufc_pkg::BLOCK_PAYLOAD};
      ufc_pkg::SEL_HDR3:  emit_word = {family_q, 15'h0000, total_q};
      ufc_pkg::SEL_DATA:  emit_word = pw_q;
      ufc_pkg::SEL_RAW:   emit_word = raw_word;
      ufc_pkg::SEL_MAGIC: emit_word = {ufc_pkg::MAGIC_Z, 32'h0000_0000};
      default:            emit_word = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ufc_pkg::RST_OUTPUT_MODE;
      total_q  <= ufc_pkg::RST_TOTAL_BLOCKS;
      base_q   <= ufc_pkg::RST_BASE_ADDRESS;
      family_q <= ufc_pkg::RST_FAMILY_WORD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ufc_pkg::CFG_OUTPUT_MODE:  mode_q   <= cfg_data_i[0];
        ufc_pkg::CFG_TOTAL_BLOCKS: total_q  <= cfg_data_i[16:0];
        ufc_pkg::CFG_BASE_ADDRESS: base_q   <= cfg_data_i;
        ufc_pkg::CFG_FAMILY_WORD:  family_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= ufc_pkg::CRC_INIT;
      block_q     <= '0;
      wib_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.crc) begin
        crc_q  <= crc_t;
        done_q <= done_q | done_t;
      end
      if (cmd_i.pad) begin
        wib_q <= wib_q + 5'd1;
      end
      if (cmd_i.finish) begin
        if (final_q) begin
          crc_q   <= ufc_pkg::CRC_INIT;
          block_q <= '0;
          wib_q   <= '0;
          done_q  <= 1'b0;
        end else begin
          wib_q <= wib_q + 5'd1;
          if (wib_q == 5'd31 && block_q < MaxBlk) begin
            block_q <= block_q + BW'(1);
          end
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_word_q <= in_word_i;
      cnt_q     <= cnt_eff;
      final_q   <= in_last_i;
      err_q     <= in_last_i & err_now;
    end
    if (cmd_i.pad) begin
      in_word_q <= '1;
      cnt_q     <= ufc_pkg::FULL_WORD;
    end
    if (cmd_i.crc) begin
      pw_q[{cmd_i.half, 5'b00000} +: 32] <= half_out;
    end
    if (cmd_i.emit) begin
      out_word_q  <= emit_word;
      out_bytes_q <= (cmd_i.sel == ufc_pkg::SEL_RAW) ? cnt_q : ufc_pkg::FULL_WORD;
      out_eos_q   <= (cmd_i.sel == ufc_pkg::SEL_RAW || cmd_i.sel == ufc_pkg::SEL_MAGIC)
                     & final_q;
      out_err_q   <= (cmd_i.sel == ufc_pkg::SEL_RAW || cmd_i.sel == ufc_pkg::SEL_MAGIC)
                     & err_q;
    end
  end

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.raw_mode   = mode_q;
  assign sts_o.final_item = final_q;
  assign sts_o.wib_zero   = (wib_q == 5'd0);
  assign sts_o.wib_last   = (wib_q == 5'd31);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_bytes_o = out_bytes_q;
  assign out_eos_o   = out_eos_q;
  assign out_err_o   = out_err_q;

endmodule

// ===== rtl/uf2_framer_with_boot_crc_unit.sv =====
// UF2 framer with boot-region CRC-32/MPEG-2: top level.
// Instantiates ufc_ctrl and ufc_datapath; uses ufc_pkg.
//
// Image words enter on the s_axis channel (tlast marks the final word),
// UF2 blocks or raw patched words leave on m_axis. The user must write registers
// through cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not enforce it.
// The first BOOT_REGION_BYTES-4 image bytes of block zero feed the CRC,
// processed four bytes per cycle; the CRC replaces the next four bytes.
// Steps for each input word:
//   raw mode, or UF2 word inside a block:   accept, both CRC halves, emit
//   UF2 first word of a block:              four header words added
//   UF2 last word of a block:               zero fill and end magic added
//   UF2 short final block: both CRC halves and an emit for each 0xFF pad word.
// In UF2 mode each block of 32 input words gives 64 output words, each input
// word taking an accept and both CRC halves; one item is handled at a time.
// Reset restores register defaults and clears CRC and block counters; no
// clearing pass. When m_axis_tready_i is low the output register holds its
// word and the sequencer waits; no input is taken until an item is done.
module uf2_framer_with_boot_crc_unit #(
  parameter int MAX_BLOCKS        = 65536,
  parameter int BOOT_REGION_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // image_word[63:0], byte_count[67:64], zero
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // out_word[63:0], out_bytes[67:64], zero
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // count_error
);

  ufc_pkg::ufc_cmd_t cmd;
  ufc_pkg::ufc_sts_t sts;
  logic [63:0]       out_word;
  logic [3:0]        out_bytes;

  ufc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ufc_datapath #(
    .MAX_BLOCKS        (MAX_BLOCKS),
    .BOOT_REGION_BYTES (BOOT_REGION_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (s_axis_tdata_i[63:0]),
    .in_count_i  (s_axis_tdata_i[67:64]),
    .in_last_i   (s_axis_tlast_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_word_o  (out_word),
    .out_bytes_o (out_bytes),
    .out_eos_o   (m_axis_tlast_o),
    .out_err_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {4'h0, out_bytes, out_word};

endmodule

// ===== tb/tb.sv =====
// Testbench for uf2_framer_with_boot_crc_unit: drives image words on the input stream and
// checks each UF2 block word or raw patched word against a built-in framer and CRC predictor.
// Depends on ufc_pkg for register indexes and framing constants; needs nothing else but the unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BLK      = 65536;
  localparam int unsigned BOOT_BYTES   = 256;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        eos;
    logic        cnt_err;
  } uf2_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = ufc_pkg::CFG_OUTPUT_MODE;
  logic [31:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic [71:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  uf2_framer_with_boot_crc_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // register shadow
  logic        raw_mode = ufc_pkg::RST_OUTPUT_MODE;
  logic [16:0] tot_blocks = ufc_pkg::RST_TOTAL_BLOCKS;
  logic [31:0] base_addr = ufc_pkg::RST_BASE_ADDRESS;
  logic [31:0] family_word = ufc_pkg::RST_FAMILY_WORD;

  // framer state
  logic [31:0] crc_acc = ufc_pkg::CRC_INIT;
  int unsigned blk_idx = 0;
  logic [4:0]  wib = '0;
  logic        boot_done = 1'b0;

  uf2_beat_t   uf2_stream_q[$];
  logic        steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned images_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned short_tails = 0;

  function automatic void expect_beat(input logic [63:0] w, input logic [3:0] nb,
                                      input logic eos, input logic err);
    uf2_beat_t b;
    b.word    = w;
    b.nbytes  = nb;
    b.eos     = eos;
    b.cnt_err = err;
    uf2_stream_q.push_back(b);
  endfunction

  function automatic logic [7:0] boot_byte(input int unsigned off, input logic [7:0] b);
    logic [7:0] r;
    int k;
    r = b;
    if (!boot_done && blk_idx == 0 && off < BOOT_BYTES) begin
      if (off + 4 < BOOT_BYTES) begin
        crc_acc = crc_acc ^ {b, 24'h00_0000};
        for (k = 0; k < 8; k++) begin
          crc_acc = crc_acc[31] ? ((crc_acc << 1) ^ ufc_pkg::CRC_POLY) : (crc_acc << 1);
        end
      end else begin
        r = 8'(crc_acc >> (8 * (off + 4 - BOOT_BYTES)));
        if (off + 1 == BOOT_BYTES) boot_done = 1'b1;
      end
    end
    return r;
  endfunction

  // bytes at or above valid are 0xFF fill
  function automatic logic [63:0] patched_word(input logic [63:0] w, input int unsigned valid,
                                               input int unsigned widx);
    logic [63:0] r;
    logic [7:0] b;
    int i;
    r = '0;
    for (i = 0; i < 8; i++) begin
      b = (i < valid) ? w[8*i +: 8] : 8'hFF;
      r[8*i +: 8] = boot_byte(widx * 8 + i, b);
    end
    return r;
  endfunction

  function automatic void frame_image_word(input logic [63:0] w, input logic [3:0] cnt_in,
                                           input logic last);
    int unsigned cnt;
    int unsigned wi;
    int unsigned i;
    logic err;
    logic [63:0] p;
    logic [31:0] addr;
    cnt = (!last || cnt_in == 0 || cnt_in > 8) ? 8 : cnt_in;
    err = last && (blk_idx >= MAX_BLK || blk_idx + 1 != tot_blocks);
    wi = wib;
    if (raw_mode) begin
      p = patched_word(w, cnt, wi);
      if (cnt < 8) p = p & ((64'd1 << (8 * cnt)) - 64'd1);
      expect_beat(p, 4'(cnt), last, err);
    end else begin
      if (wi == 0) begin
        addr = base_addr + 32'(256 * blk_idx);
        expect_beat({ufc_pkg::MAGIC_B, ufc_pkg::MAGIC_A}, ufc_pkg::FULL_WORD, 1'b0, 1'b0);
        expect_beat({addr, ufc_pkg::FLAG_FAMILY}, ufc_pkg::FULL_WORD, 1'b0, 1'b0);
        expect_beat({32'(blk_idx), ufc_pkg::BLOCK_PAYLOAD}, ufc_pkg::FULL_WORD, 1'b0, 1'b0);
        expect_beat({family_word, 15'd0, tot_blocks}, ufc_pkg::FULL_WORD, 1'b0, 1'b0);
      end
      expect_beat(patched_word(w, cnt, wi), ufc_pkg::FULL_WORD, 1'b0, 1'b0);
      if (last) begin
        if (wi < 31) short_tails++;
        while (wi < 31) begin
          wi++;
          expect_beat(patched_word('0, 0, wi), ufc_pkg::FULL_WORD, 1'b0, 1'b0);
        end
      end
      if (wi == 31) begin
        for (i = 36; i < 63; i++) expect_beat('0, ufc_pkg::FULL_WORD, 1'b0, 1'b0);
        expect_beat({ufc_pkg::MAGIC_Z, 32'h0}, ufc_pkg::FULL_WORD, last, err);
      end
    end
    if (last) begin
      crc_acc   = ufc_pkg::CRC_INIT;
      blk_idx   = 0;
      wib       = '0;
      boot_done = 1'b0;
    end else begin
      wib = 5'(wi + 1);
      if (wi == 31 && blk_idx < MAX_BLK) blk_idx++;
    end
  endfunction

  always @(posedge clk_i) begin : check_stream
    uf2_beat_t exp_b;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      beats_checked++;
      if (uf2_stream_q.size() == 0) begin
        $error("unexpected output transaction: word %h", m_axis_tdata_o[63:0]);
        mismatches++;
      end else begin
        exp_b = uf2_stream_q.pop_front();
        if (m_axis_tdata_o[63:0] !== exp_b.word) begin
          $error("out_word: expected %h, got %h", exp_b.word, m_axis_tdata_o[63:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[67:64] !== exp_b.nbytes) begin
          $error("out_bytes: expected %0d, got %0d", exp_b.nbytes, m_axis_tdata_o[67:64]);
          mismatches++;
        end
        if (m_axis_tlast_o !== exp_b.eos) begin
          $error("end_of_stream: expected %b, got %b", exp_b.eos, m_axis_tlast_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== exp_b.cnt_err) begin
          $error("count_error: expected %b, got %b", exp_b.cnt_err, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
    m_ready <= steady || ($urandom_range(0, 99) >= 11);
  end

  task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic last);
    if (!steady) begin
      while ($urandom_range(0, 99) < 11) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {4'h0, cnt, w};
    s_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    frame_image_word(w, cnt, last);
  endtask

  task automatic idle_bus();
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (uf2_stream_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic mode, input logic [16:0] total,
                           input logic [31:0] base, input logic [31:0] fam);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= ufc_pkg::CFG_OUTPUT_MODE;
    cfg_data <= {31'd0, mode};
    @(posedge clk_i);
    cfg_idx  <= ufc_pkg::CFG_TOTAL_BLOCKS;
    cfg_data <= {15'd0, total};
    @(posedge clk_i);
    cfg_idx  <= ufc_pkg::CFG_BASE_ADDRESS;
    cfg_data <= base;
    @(posedge clk_i);
    cfg_idx  <= ufc_pkg::CFG_FAMILY_WORD;
    cfg_data <= fam;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    raw_mode    = mode;
    tot_blocks  = total;
    base_addr   = base;
    family_word = fam;
  endtask

  function automatic logic [3:0] final_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  function automatic int unsigned image_len();
    case ($urandom_range(0, 4))
      0: return $urandom_range(1, 8);
      1: return $urandom_range(28, 36);
      2: return $urandom_range(60, 70);
      default: return $urandom_range(1, 100);
    endcase
  endfunction

  task automatic run_image(input int unsigned n_words);
    int unsigned i;
    logic last;
    for (i = 0; i < n_words; i++) begin
      last = (i == n_words - 1);
      send_word({$urandom, $urandom}, last ? final_count() : 4'($urandom_range(0, 15)), last);
    end
    idle_bus();
    images_sent++;
  endtask

  task automatic configure_for(input logic mode, input int unsigned n_words);
    logic [16:0] total;
    logic [31:0] base;
    total = ($urandom_range(0, 9) < 8) ? 17'((n_words + 31) / 32)
                                       : 17'($urandom_range(1, MAX_BLK));
    case ($urandom_range(0, 5))
      0: base = 32'h0;
      1: base = 32'hFFFF_FFFF;
      default: base = $urandom;
    endcase
    configure(mode, total, base, $urandom);
  endtask

  task automatic test_defaults();
    send_word({$urandom, $urandom}, 4'd3, 1'b1);
    idle_bus();
    images_sent++;
  endtask

  task automatic test_raw_edges();
    configure(1'b1, 17'd65536, 32'h0, 32'hFFFF_FFFF);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 1'b0);
    send_word(64'h0, 4'd0, 1'b0);
    send_word({$urandom, $urandom}, 4'd0, 1'b1);
    idle_bus();
    send_word({$urandom, $urandom}, 4'd15, 1'b1);
    idle_bus();
    configure(1'b1, 17'd1, 32'h0, 32'hFFFF_FFFF);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
    idle_bus();
    send_word(64'hA5A5_5A5A_0F0F_F0F0, 4'd8, 1'b1);
    idle_bus();
    images_sent += 4;
  endtask

  task automatic test_uf2_extremes();
    configure(1'b0, 17'd1, 32'hFFFF_FFFF, 32'h0);
    send_word(64'h0, 4'd9, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    idle_bus();
    configure(1'b0, 17'd65536, 32'h0, 32'hFFFF_FFFF);
    send_word({$urandom, $urandom}, 4'd7, 1'b1);
    idle_bus();
    images_sent += 2;
  endtask

  task automatic test_random_uf2(input int unsigned n_items);
    int unsigned target;
    int unsigned n;
    target = items_sent + n_items;
    while (items_sent < target) begin
      n = image_len();
      configure_for(1'b0, n);
      run_image(n);
    end
  endtask

  task automatic test_random_raw(input int unsigned n_items);
    int unsigned target;
    int unsigned n;
    target = items_sent + n_items;
    while (items_sent < target) begin
      n = image_len();
      configure_for(1'b1, n);
      run_image(n);
    end
  endtask

  task automatic test_steady_flow();
    configure_for(1'b0, 40);
    steady = 1'b1;
    run_image(40);
    configure_for(1'b1, 33);
    run_image(33);
    settle();
    steady = 1'b0;
  endtask

  // stop mid-image until the output side has drained, then resume
  task automatic test_pressure();
    int unsigned i;
    configure_for(1'b0, 45);
    for (i = 0; i < 45; i++) begin
      if (i == 20) begin
        idle_bus();
        while (uf2_stream_q.size() != 0) @(posedge clk_i);
      end
      send_word({$urandom, $urandom}, i == 44 ? final_count() : 4'($urandom_range(0, 15)),
                i == 44);
    end
    idle_bus();
    images_sent++;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_raw_edges();
    test_uf2_extremes();
    test_random_uf2(200);
    test_random_raw(80);
    test_steady_flow();
    test_pressure();
    while (uf2_stream_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Framed %0d images from %0d input words in UF2 and raw modes, %0d padded tails.",
             images_sent, items_sent, short_tails);
    $display("Checked %0d output words, %0d field mismatches.", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d output words still outstanding.", uf2_stream_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
